>>> rtl/min_max_peak_decimator_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the min/max peak decimator.
// ---------------------------------------------------------------------------
`ifndef MIN_MAX_PEAK_DECIMATOR_TOP_MACROS_SVH
`define MIN_MAX_PEAK_DECIMATOR_TOP_MACROS_SVH

// same-cycle implication, checked on every rising clock out of reset
`define MMPD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MMPD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mmpd_pkg.sv
// ---------------------------------------------------------------------------
// mmpd_pkg
// Shared constants and types of the min/max peak decimator.
// ---------------------------------------------------------------------------
package mmpd_pkg;

  localparam int SAMPLE_COUNT_W = 21;
  localparam int BUCKET_COUNT_W = 13;
  localparam int START_INDEX_W  = 20;
  localparam int BIN_W          = 21;
  localparam int VALUE_W        = 24;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 21;
  localparam int OUT_DATA_W     = 48;
  localparam int QDEPTH         = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX  = 2'd2;

  // one closed bucket, extremes already in output order
  typedef struct packed {
    logic [BIN_W-1:0]   lo_bin;
    logic [VALUE_W-1:0] lo_val;
    logic [BIN_W-1:0]   hi_bin;
    logic [VALUE_W-1:0] hi_val;
    logic               single;
    logic               frame_last;
  } rec_t;

endpackage

>>> rtl/mmpd_cfg.sv
// ---------------------------------------------------------------------------
// mmpd_cfg
// Configuration registers, count saturation and bucket-step modulo setup.
// ---------------------------------------------------------------------------
module mmpd_cfg #(
  parameter int MAX_FRAME_SAMPLES = 1048576,
  parameter int MAX_BUCKETS       = 4096,
  localparam int CW = $clog2(MAX_FRAME_SAMPLES + 1),
  localparam int BW = $clog2(MAX_BUCKETS + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [mmpd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mmpd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                               busy_o,
  output logic [CW-1:0]                      c_eff_o,
  output logic [BW-1:0]                      b_eff_o,
  output logic [CW-1:0]                      b_mod_o,
  output logic [CW-1:0]                      r_init_o,
  output logic [mmpd_pkg::START_INDEX_W-1:0] start_index_o
);

  localparam int SCW = $clog2(BW + 3);

  logic [mmpd_pkg::SAMPLE_COUNT_W-1:0] sample_count_q, sample_count_d;
  logic [mmpd_pkg::BUCKET_COUNT_W-1:0] bucket_count_q, bucket_count_d;
  logic [mmpd_pkg::START_INDEX_W-1:0]  start_index_q, start_index_d;
  logic                                busy_q, busy_d;
  logic [SCW-1:0]                      cnt_q, cnt_d;
  logic [CW-1:0]                       c_eff_q, c_eff_d;
  logic [BW-1:0]                       b_eff_q, b_eff_d;
  logic [BW-1:0]                       b_sh_q, b_sh_d;
  logic [CW-1:0]                       rem_q, rem_d;
  logic [CW-1:0]                       b_mod_q, b_mod_d;
  logic [CW-1:0]                       r_init_q, r_init_d;
  logic [31:0]                         sc_ext, bc_ext, c_sat, b_sat;
  logic [CW:0]                         rem_sh, rem_sub;

  assign sc_ext = 32'(sample_count_q);
  assign bc_ext = 32'(bucket_count_q);

  always_comb begin
    priority if (sc_ext == 32'd0) begin
      c_sat = 32'd1;
    end else if (sc_ext > 32'(MAX_FRAME_SAMPLES)) begin
      c_sat = 32'(MAX_FRAME_SAMPLES);
    end else begin
      c_sat = sc_ext;
    end
    priority if (bc_ext == 32'd0) begin
      b_sat = 32'd1;
    end else if (bc_ext > 32'(MAX_BUCKETS)) begin
      b_sat = 32'(MAX_BUCKETS);
    end else begin
      b_sat = bc_ext;
    end
  end

  assign rem_sh  = {rem_q, b_sh_q[BW-1]};
  assign rem_sub = rem_sh - {1'b0, c_eff_q};

  always_comb begin
    sample_count_d = sample_count_q;
    bucket_count_d = bucket_count_q;
    start_index_d  = start_index_q;
    busy_d         = busy_q;
    cnt_d          = cnt_q;
    c_eff_d        = c_eff_q;
    b_eff_d        = b_eff_q;
    b_sh_d         = b_sh_q;
    rem_d          = rem_q;
    b_mod_d        = b_mod_q;
    r_init_d       = r_init_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mmpd_pkg::CFG_SAMPLE_COUNT: sample_count_d = cfg_data_i;
        mmpd_pkg::CFG_BUCKET_COUNT: bucket_count_d = cfg_data_i[mmpd_pkg::BUCKET_COUNT_W-1:0];
        mmpd_pkg::CFG_START_INDEX:  start_index_d  = cfg_data_i[mmpd_pkg::START_INDEX_W-1:0];
        default: ;
      endcase
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + SCW'(1);
      if (cnt_q == '0) begin
        c_eff_d = CW'(c_sat);
        b_eff_d = BW'(b_sat);
        b_sh_d  = BW'(b_sat);
        rem_d   = '0;
      end else if (cnt_q <= SCW'(BW)) begin
        b_sh_d = b_sh_q << 1;
        rem_d  = (rem_sh >= {1'b0, c_eff_q}) ? CW'(rem_sub) : CW'(rem_sh);
      end else if (cnt_q == SCW'(BW + 1)) begin
        b_mod_d  = rem_q;
        r_init_d = (rem_q == '0) ? '0 : c_eff_q - rem_q;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= mmpd_pkg::SAMPLE_COUNT_W'(1);
      bucket_count_q <= mmpd_pkg::BUCKET_COUNT_W'(1);
      start_index_q  <= '0;
      busy_q         <= 1'b1;
      cnt_q          <= '0;
      c_eff_q        <= CW'(1);
      b_eff_q        <= BW'(1);
      b_sh_q         <= '0;
      rem_q          <= '0;
      b_mod_q        <= '0;
      r_init_q       <= '0;
    end else begin
      sample_count_q <= sample_count_d;
      bucket_count_q <= bucket_count_d;
      start_index_q  <= start_index_d;
      busy_q         <= busy_d;
      cnt_q          <= cnt_d;
      c_eff_q        <= c_eff_d;
      b_eff_q        <= b_eff_d;
      b_sh_q         <= b_sh_d;
      rem_q          <= rem_d;
      b_mod_q        <= b_mod_d;
      r_init_q       <= r_init_d;
    end
  end

  assign busy_o        = busy_q;
  assign c_eff_o       = c_eff_q;
  assign b_eff_o       = b_eff_q;
  assign b_mod_o       = b_mod_q;
  assign r_init_o      = r_init_q;
  assign start_index_o = start_index_q;

endmodule

>>> rtl/mmpd_front.sv
// ---------------------------------------------------------------------------
// mmpd_front
// Sample intake: bucket boundary tracking and first-min/first-max capture.
// ---------------------------------------------------------------------------
`include "min_max_peak_decimator_top_macros.svh"

module mmpd_front #(
  parameter int SAMPLE_BITS       = 24,
  parameter int MAX_FRAME_SAMPLES = 1048576,
  parameter int MAX_BUCKETS       = 4096,
  localparam int CW = $clog2(MAX_FRAME_SAMPLES + 1),
  localparam int BW = $clog2(MAX_BUCKETS + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               busy_i,
  input  logic [CW-1:0]                      c_eff_i,
  input  logic [BW-1:0]                      b_eff_i,
  input  logic [CW-1:0]                      b_mod_i,
  input  logic [CW-1:0]                      r_init_i,
  input  logic [mmpd_pkg::START_INDEX_W-1:0] start_index_i,
  input  logic                               valid_i,
  input  logic [mmpd_pkg::VALUE_W-1:0]       sample_i,
  output logic                               ready_o,
  input  logic                               q_full_i,
  output logic                               push_o,
  output mmpd_pkg::rec_t                     rec_o
);

  localparam int VW = (SAMPLE_BITS < mmpd_pkg::VALUE_W) ? SAMPLE_BITS : mmpd_pkg::VALUE_W;
  localparam int DW = (CW > BW) ? CW : BW;

  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] r_q, r_d;
  logic          open_q, open_d;
  logic [VW-1:0] min_val_q, min_val_d, max_val_q, max_val_d;
  logic [CW-1:0] min_idx_q, min_idx_d, max_idx_q, max_idx_d;

  logic                         accept, min_upd, max_upd, closes, frame_end;
  logic                         single, min_first, r_lt_b;
  logic [VW-1:0]                v;
  logic [CW-1:0]                idx_inc, r_next;
  logic [mmpd_pkg::BIN_W-1:0]   min_bin, max_bin;

  assign ready_o = !busy_i && !q_full_i;
  assign accept  = valid_i && ready_o;
  assign v       = sample_i[VW-1:0];

  assign min_upd   = !open_q || (v < min_val_q);
  assign max_upd   = !open_q || (v > max_val_q);
  assign idx_inc   = idx_q + CW'(1);
  assign frame_end = (idx_inc == c_eff_i);
  assign r_lt_b    = DW'(r_q) < DW'(b_eff_i);
  assign closes    = r_lt_b || frame_end;

  assign min_val_d = min_upd ? v : min_val_q;
  assign max_val_d = max_upd ? v : max_val_q;
  assign min_idx_d = min_upd ? idx_q : min_idx_q;
  assign max_idx_d = max_upd ? idx_q : max_idx_q;

  assign single = !open_q || (!min_upd && !max_upd && (min_idx_q == max_idx_q));

  always_comb begin
    priority if (min_upd && !max_upd) begin
      min_first = 1'b0;
    end else if (max_upd && !min_upd) begin
      min_first = 1'b1;
    end else begin
      min_first = min_idx_q < max_idx_q;
    end
  end

  assign min_bin = mmpd_pkg::BIN_W'(start_index_i) + mmpd_pkg::BIN_W'(min_idx_d);
  assign max_bin = mmpd_pkg::BIN_W'(start_index_i) + mmpd_pkg::BIN_W'(max_idx_d);

  always_comb begin
    if (single || min_first) begin
      rec_o.lo_bin = min_bin;
      rec_o.lo_val = mmpd_pkg::VALUE_W'(min_val_d);
      rec_o.hi_bin = max_bin;
      rec_o.hi_val = mmpd_pkg::VALUE_W'(max_val_d);
    end else begin
      rec_o.lo_bin = max_bin;
      rec_o.lo_val = mmpd_pkg::VALUE_W'(max_val_d);
      rec_o.hi_bin = min_bin;
      rec_o.hi_val = mmpd_pkg::VALUE_W'(min_val_d);
    end
    rec_o.single     = single;
    rec_o.frame_last = frame_end;
  end

  assign push_o = accept && closes;

  always_comb begin
    priority if (!r_lt_b) begin
      r_next = CW'(DW'(r_q) - DW'(b_eff_i));
    end else if (r_q >= b_mod_i) begin
      r_next = r_q - b_mod_i;
    end else begin
      r_next = CW'({1'b0, r_q} + {1'b0, c_eff_i} - {1'b0, b_mod_i});
    end
  end

  always_comb begin
    priority if (busy_i) begin
      idx_d  = '0;
      r_d    = r_init_i;
      open_d = 1'b0;
    end else if (accept) begin
      if (frame_end) begin
        idx_d  = '0;
        r_d    = r_init_i;
        open_d = 1'b0;
      end else begin
        idx_d  = idx_inc;
        r_d    = r_next;
        open_d = !closes;
      end
    end else begin
      idx_d  = idx_q;
      r_d    = r_q;
      open_d = open_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      r_q    <= '0;
      open_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      r_q    <= r_d;
      open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_val_q <= min_val_d;
      max_val_q <= max_val_d;
      min_idx_q <= min_idx_d;
      max_idx_q <= max_idx_d;
    end
  end

  `MMPD_ASSERT_IMP(a_push_room, push_o, !q_full_i, "bucket pushed into a full queue")
  `MMPD_ASSERT_IMP(a_idx_range, !busy_i, idx_q < c_eff_i, "sample index beyond frame length")
  `MMPD_ASSERT_IMP(a_min_le_max, open_q, min_val_q <= max_val_q, "bucket minimum above maximum")

endmodule

>>> rtl/mmpd_queue.sv
// ---------------------------------------------------------------------------
// mmpd_queue
// Short FIFO of closed buckets between intake and result emission.
// ---------------------------------------------------------------------------
module mmpd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mmpd_pkg::rec_t rec_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output mmpd_pkg::rec_t head_o
);

  localparam int AW  = $clog2(mmpd_pkg::QDEPTH);
  localparam int NW  = $clog2(mmpd_pkg::QDEPTH + 1);

  mmpd_pkg::rec_t mem_q [mmpd_pkg::QDEPTH];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]  cnt_q, cnt_d;

  assign full_o       = (cnt_q == NW'(mmpd_pkg::QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + AW'(1) : rd_ptr_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + NW'(1);
      2'b01:   cnt_d = cnt_q - NW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

>>> rtl/mmpd_back.sv
// ---------------------------------------------------------------------------
// mmpd_back
// Result emission: one or two beats per closed bucket into an output register.
// ---------------------------------------------------------------------------
`include "min_max_peak_decimator_top_macros.svh"

module mmpd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            head_valid_i,
  input  mmpd_pkg::rec_t                  head_i,
  output logic                            pop_o,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [mmpd_pkg::OUT_DATA_W-1:0] m_tdata_o,
  output logic                            m_tlast_o,
  output logic                            m_tuser_o
);

  localparam int PADW = mmpd_pkg::OUT_DATA_W - mmpd_pkg::BIN_W - mmpd_pkg::VALUE_W;

  logic                         phase_q, phase_d;
  logic                         valid_q, valid_d;
  logic [mmpd_pkg::BIN_W-1:0]   bin_q, bin_d;
  logic [mmpd_pkg::VALUE_W-1:0] val_q, val_d;
  logic                         run_last_q, run_last_d;
  logic                         frame_last_q, frame_last_d;
  logic                         load, last_beat;

  assign load      = head_valid_i && (!valid_q || m_tready_i);
  assign last_beat = head_i.single || phase_q;
  assign pop_o     = load && last_beat;

  always_comb begin
    phase_d = phase_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      phase_d = !last_beat;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
    if (phase_q) begin
      bin_d = head_i.hi_bin;
      val_d = head_i.hi_val;
    end else begin
      bin_d = head_i.lo_bin;
      val_d = head_i.lo_val;
    end
    run_last_d   = last_beat;
    frame_last_d = last_beat && head_i.frame_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bin_q        <= bin_d;
      val_q        <= val_d;
      run_last_q   <= run_last_d;
      frame_last_q <= frame_last_d;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {PADW'(0), val_q, bin_q};
  assign m_tlast_o  = run_last_q;
  assign m_tuser_o  = frame_last_q;

  `MMPD_ASSERT_IMP(a_pop_head, pop_o, head_valid_i, "pop from an empty queue")
  `MMPD_ASSERT_IMP(a_phase_pair, phase_q, head_valid_i && !head_i.single,
                   "second beat without a two-result bucket")
  `MMPD_ASSERT_IMP(a_frame_in_run, valid_q && frame_last_q, run_last_q,
                   "frame end outside a bucket end")

endmodule

>>> rtl/min_max_peak_decimator_top.sv
// ---------------------------------------------------------------------------
// min_max_peak_decimator_top
// Min/max peak decimator: first minimum and maximum of each bucket of a frame.
// ---------------------------------------------------------------------------
// Takes one sample per cycle while the modulo unit is idle and the queue is
// not full. Each bucket yields one or two result beats, at up to one beat per
// cycle; a two-entry bucket queue sits between the intake and the output
// register, so with buckets of two or more samples both sides run at full
// rate, and one-sample buckets stall the intake once the queue is full. After
// reset and after every configuration write the bucket-step modulo unit runs,
// one quotient bit per cycle; no sample is taken while it runs. Any
// configuration write restarts the frame and drops a partial bucket.
// ---------------------------------------------------------------------------
module min_max_peak_decimator_top #(
  parameter int SAMPLE_BITS       = 24,
  parameter int MAX_FRAME_SAMPLES = 1048576,
  parameter int MAX_BUCKETS       = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [mmpd_pkg::VALUE_W-1:0]    s_axis_tdata_i,  // [23:0] sample_value
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [mmpd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,  // [20:0] bin_index, [44:21] peak_value
  output logic                            m_axis_tlast_o,  // run_last
  output logic                            m_axis_tuser_o,  // [0] frame_last
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mmpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mmpd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int BW = $clog2(MAX_BUCKETS + 1);

  logic                               busy;
  logic [CW-1:0]                      c_eff, b_mod, r_init;
  logic [BW-1:0]                      b_eff;
  logic [mmpd_pkg::START_INDEX_W-1:0] start_index;
  logic                               push, q_full, pop, head_valid;
  mmpd_pkg::rec_t                     rec, head;

  assign cfg_ready_o = 1'b1;

  mmpd_cfg #(
    .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES),
    .MAX_BUCKETS      (MAX_BUCKETS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .busy_o       (busy),
    .c_eff_o      (c_eff),
    .b_eff_o      (b_eff),
    .b_mod_o      (b_mod),
    .r_init_o     (r_init),
    .start_index_o(start_index)
  );

  mmpd_front #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES),
    .MAX_BUCKETS      (MAX_BUCKETS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .busy_i       (busy),
    .c_eff_i      (c_eff),
    .b_eff_i      (b_eff),
    .b_mod_i      (b_mod),
    .r_init_i     (r_init),
    .start_index_i(start_index),
    .valid_i      (s_axis_tvalid_i),
    .sample_i     (s_axis_tdata_i),
    .ready_o      (s_axis_tready_o),
    .q_full_i     (q_full),
    .push_o       (push),
    .rec_o        (rec)
  );

  mmpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .rec_i       (rec),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  mmpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o),
    .m_tuser_o   (m_axis_tuser_o)
  );

endmodule

>>> sim/min_max_peak_decimator_top_tb.sv
// ---------------------------------------------------------------------------
// min_max_peak_decimator_top_tb
// Self-checking bench for the min/max peak decimator. Streams frames of
// samples under many register settings, computes the expected bucket extremes
// beat by beat and compares every result beat against them, with random
// source gaps and sink stalls.
// ---------------------------------------------------------------------------
module min_max_peak_decimator_top_tb;

  localparam int MAX_FRAME_SAMPLES = 1048576;
  localparam int MAX_BUCKETS       = 4096;
  localparam int RING_DEPTH        = 1024;
  localparam int SETTLE_CYCLES     = 8;
  localparam int QUIET_LIMIT       = 2000;
  localparam int PHASE_SAMPLES     = 300;

  localparam logic [mmpd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [mmpd_pkg::BIN_W-1:0]   bin;
    logic [mmpd_pkg::VALUE_W-1:0] peak;
    logic                         run_last;
    logic                         frame_last;
  } peak_beat_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [mmpd_pkg::VALUE_W-1:0]    s_axis_tdata_i = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [mmpd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                            m_axis_tlast_o;
  logic                            m_axis_tuser_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [mmpd_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [mmpd_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  min_max_peak_decimator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // decimator state as the predictor sees it
  logic [mmpd_pkg::SAMPLE_COUNT_W-1:0] reg_samples;
  logic [mmpd_pkg::BUCKET_COUNT_W-1:0] reg_buckets;
  logic [mmpd_pkg::START_INDEX_W-1:0]  reg_start;
  logic [mmpd_pkg::BIN_W-1:0]          cur_index;
  logic [33:0]                         scaled_pos;
  logic [33:0]                         threshold;
  logic [mmpd_pkg::VALUE_W-1:0]        min_val;
  logic [mmpd_pkg::VALUE_W-1:0]        max_val;
  logic [mmpd_pkg::BIN_W-1:0]          min_idx;
  logic [mmpd_pkg::BIN_W-1:0]          max_idx;
  logic                                bucket_open;

  peak_beat_t                   peak_ring [RING_DEPTH];
  int unsigned                  peaks_predicted = 0;
  int unsigned                  peaks_checked = 0;
  logic [mmpd_pkg::VALUE_W-1:0] sample_q [$];
  int unsigned                  samples_taken = 0;
  int unsigned                  cfg_writes = 0;
  int unsigned                  mismatches = 0;
  int unsigned                  quiet_cycles = 0;
  int unsigned                  send_idle_pct = 0;
  int unsigned                  recv_stall_pct = 0;
  peak_beat_t                   head;

  function automatic logic [63:0] frame_len();
    logic [63:0] c;
    c = 64'(reg_samples);
    if (c == 0) c = 1;
    if (c > MAX_FRAME_SAMPLES) c = MAX_FRAME_SAMPLES;
    return c;
  endfunction

  function automatic logic [63:0] bucket_num();
    logic [63:0] b;
    b = 64'(reg_buckets);
    if (b == 0) b = 1;
    if (b > MAX_BUCKETS) b = MAX_BUCKETS;
    return b;
  endfunction

  function automatic logic [63:0] round_up_to(input logic [63:0] x, input logic [63:0] c);
    return ((x + c - 1) / c) * c;
  endfunction

  function automatic void restart_frame();
    cur_index   = '0;
    scaled_pos  = '0;
    threshold   = 34'(round_up_to(bucket_num(), frame_len()));
    min_val     = '0;
    max_val     = '0;
    min_idx     = '0;
    max_idx     = '0;
    bucket_open = 1'b0;
  endfunction

  function automatic void post_peak(input int k, input logic [mmpd_pkg::BIN_W-1:0] idx,
                                    input logic [mmpd_pkg::VALUE_W-1:0] val, input logic rl,
                                    input logic fl);
    peak_beat_t beat;
    beat.bin        = reg_start + idx;
    beat.peak       = val;
    beat.run_last   = rl;
    beat.frame_last = fl;
    peak_ring[(peaks_predicted + k) % RING_DEPTH] = beat;
  endfunction

  // fold one sample into the open bucket; returns the number of beats it closes out
  function automatic int take_sample(input logic [mmpd_pkg::VALUE_W-1:0] v);
    logic [63:0] c, b, p, i;
    logic        closes, frame_end;
    int          n;
    c = frame_len();
    b = bucket_num();
    i = 64'(cur_index);
    n = 0;
    if (!bucket_open) begin
      min_val = v;
      max_val = v;
      min_idx = cur_index;
      max_idx = cur_index;
      bucket_open = 1'b1;
    end else begin
      if (v < min_val) begin
        min_val = v;
        min_idx = cur_index;
      end
      if (v > max_val) begin
        max_val = v;
        max_idx = cur_index;
      end
    end
    p = 64'(scaled_pos) + b;
    closes = 64'(threshold) < p + b;
    frame_end = (i + 1) >= c;
    if (frame_end) closes = 1'b1;
    if (closes) begin
      if (min_idx == max_idx) begin
        post_peak(0, min_idx, min_val, 1'b1, frame_end);
        n = 1;
      end else if (min_idx < max_idx) begin
        post_peak(0, min_idx, min_val, 1'b0, 1'b0);
        post_peak(1, max_idx, max_val, 1'b1, frame_end);
        n = 2;
      end else begin
        post_peak(0, max_idx, max_val, 1'b0, 1'b0);
        post_peak(1, min_idx, min_val, 1'b1, frame_end);
        n = 2;
      end
    end
    if (frame_end) begin
      restart_frame();
    end else begin
      cur_index = 21'(i + 1);
      scaled_pos = 34'(p);
      if (closes) begin
        bucket_open = 1'b0;
        threshold = 34'(round_up_to(p + b, c));
      end
    end
    return n;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < 40)
      $display("mismatch %s: got %0h, expected %0h (beat %0d)", what, got, want,
               peaks_checked);
    mismatches++;
  endtask

  // sample source
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      peaks_predicted <= peaks_predicted + take_sample(s_axis_tdata_i);
      samples_taken++;
    end
    if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata_i  <= sample_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // result sink and checker
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (peaks_checked == peaks_predicted) begin
        flag_mismatch("unexpected result beat", 32'(m_axis_tdata_o), 0);
      end else begin
        head = peak_ring[peaks_checked % RING_DEPTH];
        if (m_axis_tdata_o[mmpd_pkg::BIN_W-1:0] != head.bin)
          flag_mismatch("bin_index", 32'(m_axis_tdata_o[mmpd_pkg::BIN_W-1:0]),
                        32'(head.bin));
        if (m_axis_tdata_o[mmpd_pkg::BIN_W +: mmpd_pkg::VALUE_W] != head.peak)
          flag_mismatch("peak_value",
                        32'(m_axis_tdata_o[mmpd_pkg::BIN_W +: mmpd_pkg::VALUE_W]),
                        32'(head.peak));
        if (m_axis_tlast_o != head.run_last)
          flag_mismatch("run_last", 32'(m_axis_tlast_o), 32'(head.run_last));
        if (m_axis_tuser_o != head.frame_last)
          flag_mismatch("frame_last", 32'(m_axis_tuser_o), 32'(head.frame_last));
        peaks_checked <= peaks_checked + 1;
      end
    end
    m_axis_tready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: no beat on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [mmpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mmpd_pkg::CFG_DATA_W-1:0] data, input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    unique case (idx)
      mmpd_pkg::CFG_SAMPLE_COUNT: reg_samples = data;
      mmpd_pkg::CFG_BUCKET_COUNT: reg_buckets = data[mmpd_pkg::BUCKET_COUNT_W-1:0];
      mmpd_pkg::CFG_START_INDEX:  reg_start = data[mmpd_pkg::START_INDEX_W-1:0];
      default: ;
    endcase
    restart_frame();
    cfg_writes++;
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [mmpd_pkg::CFG_DATA_W-1:0] sc,
                          input logic [mmpd_pkg::CFG_DATA_W-1:0] bc,
                          input logic [mmpd_pkg::CFG_DATA_W-1:0] si);
    cfg_write(mmpd_pkg::CFG_SAMPLE_COUNT, sc, 1'b0);
    cfg_write(mmpd_pkg::CFG_BUCKET_COUNT, bc, 1'b0);
    cfg_write(mmpd_pkg::CFG_START_INDEX, si, 1'b1);
  endtask

  // hold until every sample is taken and every result beat has come back
  task automatic drain();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid_i || peaks_checked != peaks_predicted);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [mmpd_pkg::VALUE_W-1:0] pick_sample();
    unique case ($urandom_range(3))
      0: return mmpd_pkg::VALUE_W'($urandom_range(3));
      1: return $urandom_range(1) ? {mmpd_pkg::VALUE_W{1'b1}} :
                mmpd_pkg::VALUE_W'($urandom_range(7));
      default: return mmpd_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned sc, bc, si, seg_len, phase_items, sel;
    reg_samples = 1;
    reg_buckets = 1;
    reg_start   = '0;
    restart_frame();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one-sample frames
    sample_q.push_back(24'h000000);
    sample_q.push_back(24'hFFFFFF);
    drain();
    // zero counts behave as one
    set_regs(0, 0, 0);
    sample_q.push_back(24'h5A5A5A);
    drain();
    // more buckets than half the samples; last bucket holds two equal values
    set_regs(5, 4, 17);
    sample_q = {24'd9, 24'd2, 24'hFFFFFF, 24'd5, 24'd5};
    drain();
    // more buckets than samples: empty buckets stay silent
    set_regs(3, 8, 100);
    sample_q = {24'd1, 24'd2, 24'd3};
    drain();
    // partial bucket dropped by a write to the spare index, then ties in both orders
    set_regs(6, 2, 20'hFFFFF);
    sample_q = {24'd4, 24'd8};
    drain();
    cfg_write(CFG_SPARE, {mmpd_pkg::CFG_DATA_W{1'b1}}, 1'b1);
    sample_q = {24'd7, 24'd3, 24'd3, 24'd9, 24'd9, 24'd1};
    drain();
    // both counts past their limits: saturated frame of 256-sample buckets
    set_regs({mmpd_pkg::CFG_DATA_W{1'b1}}, {mmpd_pkg::CFG_DATA_W{1'b1}}, 0);
    repeat (600) sample_q.push_back(pick_sample());
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_SAMPLES) begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          sc = $urandom_range(1, 48);
          bc = $urandom_range(1, (sc / 2 > 1) ? sc / 2 : 1);
          seg_len = sc * $urandom_range(1, 3);
          if ($urandom_range(3) == 0) seg_len += $urandom_range(0, sc - 1);
        end else if (sel < 85) begin
          sc = $urandom_range(1, 16);
          bc = $urandom_range(sc / 2 + 1, 40);
          seg_len = sc * $urandom_range(1, 4);
        end else if (sel < 92) begin
          sc = $urandom_range(1) ? 0 : $urandom_range(2, 20);
          bc = $urandom_range(1) ? 0 : $urandom_range(1, 5);
          seg_len = ((sc == 0) ? 1 : sc) * 2;
        end else begin
          sc = $urandom_range(0, 21'h1FFFFF);
          bc = $urandom_range(0, 13'h1FFF);
          seg_len = $urandom_range(20, 80);
        end
        si = ($urandom_range(3) == 0) ? 20'hFFFFF : 20'($urandom);
        set_regs(21'(sc), {8'($urandom), 13'(bc)}, {1'($urandom), 20'(si)});
        repeat (seg_len) sample_q.push_back(pick_sample());
        phase_items += seg_len;
        drain();
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    $display("%0d samples streamed, %0d result beats checked, %0d register writes",
             samples_taken, peaks_checked, cfg_writes);
    $display("covered corner settings, saturated counts and four gap/stall mixes");
    if (mismatches == 0 && peaks_checked == peaks_predicted) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
